@@ src/attt_pkg.sv @@
// ----------------------------------------------------------------------------
// attt_pkg
// Shared types and constants of the acknowledgement timeout tracker.
// ----------------------------------------------------------------------------
package attt_pkg;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 32;
  localparam int CLK_W   = 31;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CLK_W-1:0]  CLOCK_MAX     = {CLK_W{1'b1}};
  localparam logic [CLK_W-1:0]  CLOCK_RESET   = CLK_W'(1);
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(60000);

  // operation codes
  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SENT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACKED    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESEND   = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic free_en;
    logic ack_en;
    logic rd_en;
  } attt_tbl_ctrl_t;

  typedef struct packed {
    logic ack_hit;
    logic due;
  } attt_match_t;

endpackage

@@ src/attt_if.sv @@
// ----------------------------------------------------------------------------
// attt_if
// Valid/ready channels for input transactions and result transactions.
// ----------------------------------------------------------------------------
interface attt_in_if import attt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   dest_addr;
  logic [CLK_W-1:0]    peer_clock;
  logic [TIME_W-1:0]   now;

  modport source (output valid, operation, dest_addr, peer_clock, now, input ready);
  modport sink   (input valid, operation, dest_addr, peer_clock, now, output ready);
endinterface

interface attt_out_if import attt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   dest_out;
  logic [CLK_W-1:0]    clock_value;
  logic                last;

  modport source (output valid, kind, slot, dest_out, clock_value, last, input ready);
  modport sink   (input valid, kind, slot, dest_out, clock_value, last, output ready);
endinterface

@@ src/attt_slot_table.sv @@
// ----------------------------------------------------------------------------
// attt_slot_table
// Sent-packet slot store: destination and send time memories, valid and
// acknowledged flags, one write address and one registered read port.
// ----------------------------------------------------------------------------
module attt_slot_table import attt_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int IW    = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  attt_tbl_ctrl_t      ctrl,
  input  logic [IW-1:0]       op_addr,
  input  logic [ADDR_W-1:0]   wr_dest,
  input  logic [TIME_W-1:0]   wr_time,
  input  logic [IW-1:0]       rd_addr,
  output logic                rd_valid,
  output logic                rd_acked,
  output logic [ADDR_W-1:0]   rd_dest,
  output logic [TIME_W-1:0]   rd_time
);

  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  acked_r;
  logic [ADDR_W-1:0] mem_dest [SLOTS];
  logic [TIME_W-1:0] mem_time [SLOTS];
  logic              rd_valid_r;
  logic              rd_acked_r;
  logic [ADDR_W-1:0] rd_dest_r;
  logic [TIME_W-1:0] rd_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      acked_r    <= '0;
      rd_valid_r <= 1'b0;
      rd_acked_r <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        valid_r[op_addr] <= 1'b1;
        acked_r[op_addr] <= 1'b0;
      end
      if (ctrl.free_en) begin
        valid_r[op_addr] <= 1'b0;
      end
      if (ctrl.ack_en) begin
        acked_r[op_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
        rd_acked_r <= acked_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_dest[op_addr] <= wr_dest;
      mem_time[op_addr] <= wr_time;
    end
    if (ctrl.rd_en) begin
      rd_dest_r <= mem_dest[rd_addr];
      rd_time_r <= mem_time[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_acked = rd_acked_r;
  assign rd_dest  = rd_dest_r;
  assign rd_time  = rd_time_r;

endmodule

@@ src/attt_match_unit.sv @@
// ----------------------------------------------------------------------------
// attt_match_unit
// Shared per-slot check: destination match for acknowledgements and
// age against timeout for ticks.
// ----------------------------------------------------------------------------
module attt_match_unit import attt_pkg::*; (
  input  logic [OP_W-1:0]     op,
  input  logic                entry_valid,
  input  logic                entry_acked,
  input  logic [ADDR_W-1:0]   entry_dest,
  input  logic [TIME_W-1:0]   entry_time,
  input  logic [ADDR_W-1:0]   key_dest,
  input  logic [TIME_W-1:0]   now,
  input  logic [TIME_W-1:0]   timeout,
  output attt_match_t         result
);

  logic [TIME_W-1:0] age;
  logic              in_use;

  // age wraps modulo 2^32
  assign age    = now - entry_time;
  assign in_use = entry_valid && (entry_dest != '0);

  assign result.ack_hit = (op == OP_ACK) && in_use && (entry_dest == key_dest);
  assign result.due     = (op == OP_TICK) && in_use && !entry_acked && (age > timeout);

endmodule

@@ src/ack_timeout_tracker_logical_clock.sv @@
// ----------------------------------------------------------------------------
// ack_timeout_tracker_logical_clock
// Retransmission timer table with a saturating logical clock.
// ----------------------------------------------------------------------------
// Send and request transactions are accepted and then hand their result to
// the output register. Acknowledgement and tick transactions walk the slot
// table one slot per cycle, while no due result waits on a stalled output,
// through the single registered read port and the shared match unit; a tick
// that reaches 16 results ends its walk at that slot. A result that meets a
// stalled output is held until the output register is free. The input is not
// ready until the current transaction has passed its last result to the
// output register. A tick reports at most 16 slots, lowest index first;
// further due slots wait for a later tick.
// ----------------------------------------------------------------------------
module ack_timeout_tracker_logical_clock import attt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [TIME_W-1:0]   cfg_wr_data,
  attt_in_if.sink             in_item,
  attt_out_if.source          out_item
);

  localparam int IW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   timeout_r;
  logic [CLK_W-1:0]    lclock_r, lclock_nxt;
  logic [IW-1:0]       next_slot_r, next_slot_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [ADDR_W-1:0]   key_dest_r, key_dest_nxt;
  logic [TIME_W-1:0]   key_now_r, key_now_nxt;

  logic                pend_r, pend_nxt;
  logic [KIND_W-1:0]   pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [ADDR_W-1:0]   pend_dest_r, pend_dest_nxt;
  logic [CLK_W-1:0]    pend_clock_r, pend_clock_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [ADDR_W-1:0]   out_dest_r, out_dest_nxt;
  logic [CLK_W-1:0]    out_clock_r, out_clock_nxt;
  logic                out_last_r, out_last_nxt;

  attt_tbl_ctrl_t      tbl_ctrl;
  logic [IW-1:0]       tbl_op_addr;
  logic [IW-1:0]       tbl_rd_addr;
  logic                rd_valid;
  logic                rd_acked;
  logic [ADDR_W-1:0]   rd_dest;
  logic [TIME_W-1:0]   rd_time;
  attt_match_t         match;

  logic                in_acc;
  logic                out_busy;
  logic [CLK_W-1:0]    raised_clock;
  logic                last_idx;
  logic                finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  attt_slot_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (tbl_ctrl),
    .op_addr  (tbl_op_addr),
    .wr_dest  (in_item.dest_addr),
    .wr_time  (in_item.now),
    .rd_addr  (tbl_rd_addr),
    .rd_valid (rd_valid),
    .rd_acked (rd_acked),
    .rd_dest  (rd_dest),
    .rd_time  (rd_time)
  );

  attt_match_unit u_match (
    .op          (op_r),
    .entry_valid (rd_valid),
    .entry_acked (rd_acked),
    .entry_dest  (rd_dest),
    .entry_time  (rd_time),
    .key_dest    (key_dest_r),
    .now         (key_now_r),
    .timeout     (timeout_r),
    .result      (match)
  );

  assign in_item.ready = (state_r == ST_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;
  assign out_busy      = out_valid_r && !out_item.ready;
  assign raised_clock  = (in_item.peer_clock > lclock_r) ? in_item.peer_clock : lclock_r;
  assign last_idx      = (idx_r == IW'(SLOTS - 1));

  always_comb begin
    state_nxt      = state_r;
    lclock_nxt     = lclock_r;
    next_slot_nxt  = next_slot_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    key_dest_nxt   = key_dest_r;
    key_now_nxt    = key_now_r;
    pend_nxt       = pend_r;
    pend_kind_nxt  = pend_kind_r;
    pend_slot_nxt  = pend_slot_r;
    pend_dest_nxt  = pend_dest_r;
    pend_clock_nxt = pend_clock_r;
    out_valid_nxt  = out_busy;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_dest_nxt   = out_dest_r;
    out_clock_nxt  = out_clock_r;
    out_last_nxt   = out_last_r;
    tbl_ctrl       = '0;
    tbl_op_addr    = idx_r;
    tbl_rd_addr    = '0;
    finish         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_item.operation;
          key_dest_nxt = in_item.dest_addr;
          key_now_nxt  = in_item.now;
          idx_nxt      = '0;
          cnt_nxt      = '0;
          case (in_item.operation)
            OP_SEND: begin
              tbl_ctrl.wr_en = 1'b1;
              tbl_op_addr    = next_slot_r;
              pend_nxt       = 1'b1;
              pend_kind_nxt  = KIND_SENT;
              pend_slot_nxt  = SLOT_W'(next_slot_r);
              pend_dest_nxt  = in_item.dest_addr;
              pend_clock_nxt = lclock_r;
              next_slot_nxt  = (next_slot_r == IW'(SLOTS - 1)) ? '0 : next_slot_r + IW'(1);
              if (lclock_r != CLOCK_MAX) begin
                lclock_nxt = lclock_r + CLK_W'(1);
              end
              state_nxt = ST_FIN;
            end
            OP_REQUEST: begin
              lclock_nxt     = raised_clock;
              pend_nxt       = 1'b1;
              pend_kind_nxt  = KIND_REPLY;
              pend_slot_nxt  = '0;
              pend_dest_nxt  = '0;
              pend_clock_nxt = raised_clock;
              state_nxt      = ST_FIN;
            end
            OP_ACK: begin
              lclock_nxt     = raised_clock;
              pend_nxt       = 1'b1;
              pend_kind_nxt  = KIND_ACKED;
              pend_slot_nxt  = '0;
              pend_dest_nxt  = in_item.dest_addr;
              pend_clock_nxt = raised_clock;
              tbl_ctrl.rd_en = 1'b1;
              state_nxt      = ST_EVAL;
            end
            default: begin
              pend_nxt       = 1'b0;
              tbl_ctrl.rd_en = 1'b1;
              state_nxt      = ST_EVAL;
            end
          endcase
        end
      end

      ST_EVAL: begin
        if (!(match.due && pend_r && out_busy)) begin
          if (match.ack_hit) begin
            tbl_ctrl.ack_en = 1'b1;
          end
          if (match.due) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_slot_nxt  = pend_slot_r;
              out_dest_nxt  = pend_dest_r;
              out_clock_nxt = pend_clock_r;
              out_last_nxt  = 1'b0;
            end
            tbl_ctrl.free_en = 1'b1;
            pend_nxt         = 1'b1;
            pend_kind_nxt    = KIND_RESEND;
            pend_slot_nxt    = SLOT_W'(idx_r);
            pend_dest_nxt    = rd_dest;
            pend_clock_nxt   = lclock_r;
            cnt_nxt          = cnt_r + CNT_W'(1);
          end
          finish = last_idx || (match.due && (cnt_r == CNT_W'(MAX_RESULTS - 1)));
          if (finish) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt        = idx_r + IW'(1);
            tbl_rd_addr    = idx_r + IW'(1);
            tbl_ctrl.rd_en = 1'b1;
          end
        end
      end

      ST_FIN: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_slot_nxt  = pend_slot_r;
          out_dest_nxt  = pend_dest_r;
          out_clock_nxt = pend_clock_r;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lclock_r    <= CLOCK_RESET;
      next_slot_r <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lclock_r    <= lclock_nxt;
      next_slot_r <= next_slot_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_dest_r   <= key_dest_nxt;
    key_now_r    <= key_now_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_dest_r  <= pend_dest_nxt;
    pend_clock_r <= pend_clock_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_dest_r   <= out_dest_nxt;
    out_clock_r  <= out_clock_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.kind        = out_kind_r;
  assign out_item.slot        = out_slot_r;
  assign out_item.dest_out    = out_dest_r;
  assign out_item.clock_value = out_clock_r;
  assign out_item.last        = out_last_r;

  // logical clock never goes backwards and never reaches zero
  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    lclock_r >= $past(lclock_r)) else $error("logical clock decreased");

  a_clock_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lclock_r != '0) else $error("logical clock is zero");

  // a tick never reports more results than the limit
  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS)) else $error("too many results on one tick");

  // returning to idle leaves no held result behind
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_r) else $error("held result lost at idle");

  // a send is always held for output in the finishing state on the following cycle
  a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.operation == OP_SEND) |=> state_r == ST_FIN && pend_r)
    else $error("send transaction not held for output");

endmodule

@@ tb/attt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attt_checker
// Watches the input, result and register ports of the timeout tracker, keeps
// its own copy of the slot table, logical clock and timeout, works out the
// results of every accepted input transaction and compares each accepted
// result with the oldest one still waiting, field by field.
// ----------------------------------------------------------------------------
module attt_checker import attt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  attt_in_if                in_ch,
  attt_out_if               out_ch,
  output int                mismatches,
  output int                outstanding,
  output int                results_checked
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] dest;
    logic [CLK_W-1:0]  stamp;
    logic              last;
  } tracker_result_t;

  tracker_result_t   pending_results[$];
  logic [TIME_W-1:0] timeout_limit;
  logic [CLK_W-1:0]  lamport;
  int                write_slot;
  logic [ADDR_W-1:0] slot_dest  [SLOTS];
  logic              slot_acked [SLOTS];
  logic [TIME_W-1:0] slot_sent  [SLOTS];

  task automatic report(input string msg);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_transaction(input logic [OP_W-1:0] op,
                                     input logic [ADDR_W-1:0] dest,
                                     input logic [CLK_W-1:0] peer,
                                     input logic [TIME_W-1:0] now);
    tracker_result_t r;
    int hits;
    hits = 0;
    case (op)
      OP_SEND: begin
        r = '{KIND_SENT, SLOT_W'(write_slot), dest, lamport, 1'b1};
        pending_results.push_back(r);
        slot_dest[write_slot]  = dest;
        slot_acked[write_slot] = 1'b0;
        slot_sent[write_slot]  = now;
        write_slot = (write_slot == SLOTS - 1) ? 0 : write_slot + 1;
        if (lamport != CLOCK_MAX) lamport = lamport + 1'b1;
      end
      OP_REQUEST: begin
        if (peer > lamport) lamport = peer;
        r = '{KIND_REPLY, SLOT_W'(0), ADDR_W'(0), lamport, 1'b1};
        pending_results.push_back(r);
      end
      OP_ACK: begin
        if (peer > lamport) lamport = peer;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_dest[i] != '0 && slot_dest[i] == dest) slot_acked[i] = 1'b1;
        end
        r = '{KIND_ACKED, SLOT_W'(0), dest, lamport, 1'b1};
        pending_results.push_back(r);
      end
      default: begin
        // age is taken modulo 2^32
        for (int i = 0; i < SLOTS; i++) begin
          if (hits < MAX_RESULTS && slot_dest[i] != '0 && !slot_acked[i] &&
              TIME_W'(now - slot_sent[i]) > timeout_limit) begin
            r = '{KIND_RESEND, SLOT_W'(i), slot_dest[i], lamport, 1'b0};
            pending_results.push_back(r);
            hits++;
            slot_dest[i]  = '0;
            slot_acked[i] = 1'b0;
            slot_sent[i]  = '0;
          end
        end
        if (hits > 0) pending_results[pending_results.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      timeout_limit   = TIMEOUT_RESET;
      lamport         = CLOCK_RESET;
      write_slot      = 0;
      mismatches      = 0;
      results_checked = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_dest[i]  = '0;
        slot_acked[i] = 1'b0;
        slot_sent[i]  = '0;
      end
    end else begin
      if (cfg_wr_en) timeout_limit = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        predict_transaction(in_ch.operation, in_ch.dest_addr, in_ch.peer_clock, in_ch.now);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report($sformatf("result kind %0d slot %0d with nothing expected",
                           out_ch.kind, out_ch.slot));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", out_ch.kind, want.kind));
          if (out_ch.slot !== want.slot)
            report($sformatf("slot %0d, expected %0d", out_ch.slot, want.slot));
          if (out_ch.dest_out !== want.dest)
            report($sformatf("dest_out %h, expected %h", out_ch.dest_out, want.dest));
          if (out_ch.clock_value !== want.stamp)
            report($sformatf("clock_value %h, expected %h", out_ch.clock_value, want.stamp));
          if (out_ch.last !== want.last)
            report($sformatf("last %b, expected %b", out_ch.last, want.last));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/tb_ack_timeout_tracker_logical_clock.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ack_timeout_tracker_logical_clock
// Drives sends, requests, acknowledgements and ticks into the tracker under
// three idling patterns and several timeout settings, from zero to the
// largest value; results are checked by attt_checker beside the block.
// ----------------------------------------------------------------------------
module tb_ack_timeout_tracker_logical_clock;
  import attt_pkg::*;

  localparam int SLOTS       = 16;
  localparam int PHASE_ITEMS = 118;
  localparam int PEER_RAMP   = 370;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;
  logic              sink_ready = 1'b0;
  int                tx_idle;
  int                rx_idle;
  int                mismatches;
  int                outstanding;
  int                results_checked;
  int                n_offered;
  int                n_settings;
  logic [TIME_W-1:0] cur_timeout;
  logic [TIME_W-1:0] wall;
  logic [ADDR_W-1:0] dest_pool [8];

  attt_in_if  in_ch ();
  attt_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  ack_timeout_tracker_logical_clock #(.SLOTS(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_ch),
    .out_item    (out_ch)
  );

  attt_checker #(.SLOTS(SLOTS)) tracker_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic offer_transaction(input logic [OP_W-1:0] op,
                                   input logic [ADDR_W-1:0] dest,
                                   input logic [CLK_W-1:0] peer,
                                   input logic [TIME_W-1:0] stamp_now);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.dest_addr  <= dest;
    in_ch.peer_clock <= peer;
    in_ch.now        <= stamp_now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_offered++;
  endtask

  // let every result drain and the slot scan finish
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TIME_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_timeout = value;
    n_settings++;
  endtask

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int                phase_start;
    int                pick;
    int                bits;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] dest;
    logic [CLK_W-1:0]  peer;
    logic [TIME_W-1:0] stamp_now;

    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_SEND;
    in_ch.dest_addr  <= '0;
    in_ch.peer_clock <= '0;
    in_ch.now        <= '0;
    tx_idle     = 31;
    rx_idle     = 83;
    n_offered   = 0;
    n_settings  = 0;
    cur_timeout = TIMEOUT_RESET;
    wall        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, default timeout
    offer_transaction(OP_SEND, 32'hFFFF_FFFF, '0, 32'd0);
    offer_transaction(OP_SEND, '0, '0, 32'd0);
    offer_transaction(OP_REQUEST, '0, '0, '0);
    offer_transaction(OP_REQUEST, '0, 31'd10, '0);
    offer_transaction(OP_ACK, 32'hFFFF_FFFF, '0, '0);
    offer_transaction(OP_ACK, '0, '0, '0);
    offer_transaction(OP_SEND, 32'h1234_5678, '0, 32'd100);
    offer_transaction(OP_TICK, '0, '0, 32'd100);
    offer_transaction(OP_TICK, '0, '0, 32'd100 + TIMEOUT_RESET);
    offer_transaction(OP_TICK, '0, '0, 32'd101 + TIMEOUT_RESET);
    // zero timeout, age wrapping through 2^32
    set_timeout('0);
    offer_transaction(OP_SEND, 32'hA5A5_A5A5, '0, 32'hFFFF_FFF0);
    offer_transaction(OP_TICK, '0, '0, 32'hFFFF_FFF0);
    offer_transaction(OP_TICK, '0, '0, 32'd5);
    set_timeout('1);
    offer_transaction(OP_SEND, 32'h0000_0007, '0, 32'd5);
    offer_transaction(OP_TICK, '0, '0, 32'd4);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle = 31;
          rx_idle = 83;
          set_timeout(32'd1);
        end
        1: begin
          tx_idle = 83;
          rx_idle = 31;
          set_timeout($urandom_range(100000, 1000));
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
          set_timeout($urandom);
        end
      endcase
      for (int k = 0; k < 8; k++) dest_pool[k] = $urandom | 32'h1;
      wall = $urandom;
      phase_start = n_offered;
      while (n_offered - phase_start < PHASE_ITEMS) begin
        if ((phase == 0 && n_offered == phase_start) || $urandom_range(99) < 2) begin
          // fill the whole table, then one tick with every slot due
          for (int k = 0; k < SLOTS; k++) offer_transaction(OP_SEND, $urandom | 32'h1, '0, wall);
          wall = wall + cur_timeout + 1'b1;
          offer_transaction(OP_TICK, '0, '0, wall);
        end else begin
          pick = $urandom_range(99);
          if (pick < 6) dest = '0;
          else if (pick < 14) dest = $urandom;
          else dest = dest_pool[$urandom_range(7)];
          bits = 4 + (n_offered * 26) / PEER_RAMP;
          if (bits > 30) bits = 30;
          peer = CLK_W'($urandom) & ((CLK_W'(1) << bits) - 1'b1);
          wall = wall + $urandom_range((cur_timeout >> 2) + 1);
          stamp_now = ($urandom_range(99) < 5) ? TIME_W'($urandom) : wall;
          pick = $urandom_range(99);
          if (pick < 35) op = OP_SEND;
          else if (pick < 50) op = OP_REQUEST;
          else if (pick < 68) op = OP_ACK;
          else op = OP_TICK;
          offer_transaction(op, dest, peer, stamp_now);
        end
      end
    end

    // logical clock driven up to saturation
    offer_transaction(OP_REQUEST, '0, CLOCK_MAX - 1'b1, $urandom);
    offer_transaction(OP_SEND, 32'h8000_0000, '0, wall);
    offer_transaction(OP_SEND, $urandom, '0, wall);
    offer_transaction(OP_ACK, 32'h8000_0000, CLOCK_MAX, wall);
    offer_transaction(OP_TICK, '0, '0, $urandom);

    wait_idle();
    $display("run covered %0d input transactions and %0d checked results,",
             n_offered, results_checked);
    $display("with %0d timeout writes, full-table ticks and clock saturation", n_settings);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
